/* hdl/fpcc_pkg.sv */
package fpcc_pkg;

  localparam int WIN     = 512;
  localparam int AW      = $clog2(WIN);
  localparam int HALF    = WIN / 2;
  localparam int SBITS   = 16;
  localparam int DW      = 28;
  localparam int TWW     = 19;
  localparam int PW      = DW + TWW;
  localparam int MAGW    = 25;
  localparam int SQW     = 2 * MAGW;
  localparam int BW      = 2 * MAGW + 2;
  localparam int STGW    = $clog2(AW);
  localparam int RND_SH  = 17;

  localparam logic [MAGW-1:0] OUT_MAX = {MAGW{1'b1}};
  localparam logic [63:0]     PI_Q30  = 64'd3373259426;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_BUILD = 2'd1,
    OP_PUSH  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // template symbol codes
  localparam logic [1:0] TC_POS = 2'd0;
  localparam logic [1:0] TC_PJ  = 2'd1;
  localparam logic [1:0] TC_NEG = 2'd2;
  localparam logic [1:0] TC_NJ  = 2'd3;

  typedef logic signed [TWW-1:0] tw_tab_t [0:HALF];

  localparam logic [63:0] SIN_DIV [7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                          64'd110, 64'd156, 64'd210};
  localparam logic [63:0] COS_DIV [7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                          64'd90, 64'd132, 64'd182};

  // {sin, cos} of a Q2.30 angle in [0, pi/4], each Q1.17
  function automatic logic [35:0] sincos_q17(input logic [63:0] x);
    logic [63:0] x2, ts, tc, su, cu;
    longint ss, cs;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    ss = longint'(x);
    cs = longint'(64'd1 << 30);
    for (int n = 1; n <= 7; n++) begin
      ts = (((ts * x2 + (64'd1 << 29)) >> 30) + SIN_DIV[n-1] / 2) / SIN_DIV[n-1];
      tc = (((tc * x2 + (64'd1 << 29)) >> 30) + COS_DIV[n-1] / 2) / COS_DIV[n-1];
      if ((n % 2) == 1) begin
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
      end
    end
    if (ss < 0) ss = 0;
    if (cs < 0) cs = 0;
    su = (64'(ss) + 64'd4096) >> 13;
    cu = (64'(cs) + 64'd4096) >> 13;
    return {su[17:0], cu[17:0]};
  endfunction

  // {sin, cos} of 2 pi m / WIN for m up to WIN/4
  function automatic logic [35:0] quarter(input int m);
    logic [63:0] x;
    logic [35:0] t;
    if (8 * m <= WIN) begin
      x = (64'd2 * 64'(m) * PI_Q30 + 64'(WIN / 2)) / WIN;
      t = sincos_q17(x);
    end else begin
      x = (64'd2 * 64'(WIN / 4 - m) * PI_Q30 + 64'(WIN / 2)) / WIN;
      t = sincos_q17(x);
      t = {t[17:0], t[35:18]};
    end
    return t;
  endfunction

  // twiddle table: real part when im_sel is 0, imaginary part otherwise
  function automatic tw_tab_t build_tw(input logic im_sel);
    tw_tab_t tab;
    logic [35:0] q;
    logic signed [TWW-1:0] s, c;
    for (int k = 0; k <= HALF; k++) begin
      if (4 * k <= WIN) begin
        q = quarter(k);
        c = TWW'(signed'({1'b0, q[17:0]}));
      end else begin
        q = quarter(HALF - k);
        c = -TWW'(signed'({1'b0, q[17:0]}));
      end
      s = TWW'(signed'({1'b0, q[35:18]}));
      tab[k] = im_sel ? -s : c;
    end
    return tab;
  endfunction

endpackage

/* hdl/fft_peak_code_correlator.sv */
// Spreading-code correlator. Op 0 writes one code bit; op 1 builds the {+1,+j,-1,-j}
// template; op 2 shifts a sample into the 512-entry window and returns one
// peak_magnitude after it loads the window times template in bit-reversed order, runs
// 2304 radix-2 butterflies (each a read, multiply, sum, write-a and write-b step) on a
// single scratch memory with one write port, scans for the peak and takes the square
// root. Op 3 is dropped. After reset a clearing pass zeroes the code, template and
// window memories; in_stall_o stays high until it finishes.
module fft_peak_code_correlator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       op_i,
  input  logic [fpcc_pkg::AW-1:0]          index_i,
  input  logic                             prn_bit_i,
  input  logic signed [fpcc_pkg::SBITS-1:0] sample_re_i,
  input  logic signed [fpcc_pkg::SBITS-1:0] sample_im_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [fpcc_pkg::MAGW-1:0]        peak_magnitude_o
);
  import fpcc_pkg::*;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_BLD_RD, ST_BLD_WR, ST_LD_RD, ST_LD_WR,
    ST_BF_RD, ST_BF_MUL, ST_BF_SUM, ST_BF_WA, ST_BF_WB,
    ST_PK_RD, ST_PK_SQ, ST_PK_CMP, ST_SQRT, ST_FIN
  } state_e;

  localparam tw_tab_t TW_RE = build_tw(1'b0);
  localparam tw_tab_t TW_IM = build_tw(1'b1);

  state_e state_q;
  logic [AW-1:0]   cnt_q, hd_q;
  logic [STGW-1:0] stg_q;
  logic [AW-2:0]   bfn_q;
  logic            prev_bit_q, iv_q, qv_q;

  logic                    code_mem [WIN];
  logic [1:0]              tmpl_mem [WIN];
  logic [2*SBITS-1:0]      win_mem  [WIN];
  logic [2*DW-1:0]         fft_mem  [WIN];

  logic                    code_rd_q;
  logic [1:0]              tmpl_rd_q;
  logic [2*SBITS-1:0]      win_rd_q;
  logic [2*DW-1:0]         rda_q, rdb_q;

  logic signed [TWW-1:0]   tw_re_q, tw_im_q;
  logic signed [PW-1:0]    p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [DW-1:0]    tr_q, ti_q;
  logic [SQW-1:0]          sq_re_q, sq_im_q;
  logic [SQW:0]            best_q;
  logic                    sat_q;
  logic [BW-1:0]           v_q, r_q, bit_q;
  logic                    out_valid_q;
  logic [MAGW-1:0]         peak_q;

  logic accept;
  logic cnt_last;
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign cnt_last   = &cnt_q;

  // butterfly addressing
  logic [AW-2:0] lowmask, jj;
  logic [AW-1:0] a_addr, b_addr, brev;
  logic [AW-2:0] tw_idx;
  always_comb begin
    lowmask = (AW-1)'((32'd1 << stg_q) - 32'd1);
    jj      = bfn_q & lowmask;
    a_addr  = {bfn_q & ~lowmask, 1'b0} | {1'b0, jj};
    b_addr  = a_addr | AW'(32'd1 << stg_q);
    tw_idx  = (AW-1)'(32'(jj) << ((AW - 1) - 32'(stg_q)));
    for (int i = 0; i < AW; i++) brev[i] = cnt_q[AW-1-i];
  end

  // template symbol for the current code bit
  logic d_bit, iv_n, qv_n;
  logic [1:0] tc_n;
  always_comb begin
    d_bit = (cnt_q == '0) ? code_rd_q : (code_rd_q ^ prev_bit_q);
    if (cnt_q == '0) begin
      iv_n = 1'b0;
      qv_n = d_bit;
    end else if (cnt_q[0]) begin
      iv_n = d_bit ^ iv_q;
      qv_n = qv_q;
    end else begin
      iv_n = iv_q;
      qv_n = d_bit ^ iv_q;
    end
    case (cnt_q[1:0])
      2'd0:    tc_n = iv_n ? TC_NEG : TC_POS;
      2'd1:    tc_n = qv_n ? TC_PJ  : TC_NJ;
      2'd2:    tc_n = iv_n ? TC_POS : TC_NEG;
      default: tc_n = qv_n ? TC_NJ  : TC_PJ;
    endcase
  end

  // window sample times template symbol
  logic signed [SBITS:0] s_re, s_im, pr, pi;
  always_comb begin
    s_re = signed'({win_rd_q[2*SBITS-1], win_rd_q[2*SBITS-1:SBITS]});
    s_im = signed'({win_rd_q[SBITS-1], win_rd_q[SBITS-1:0]});
    case (tmpl_rd_q)
      TC_POS:  begin pr = s_re;  pi = s_im;  end
      TC_PJ:   begin pr = -s_im; pi = s_re;  end
      TC_NEG:  begin pr = -s_re; pi = -s_im; end
      default: begin pr = s_im;  pi = -s_re; end
    endcase
  end

  // butterfly datapath
  logic signed [DW-1:0] a_re, a_im, b_re, b_im;
  logic signed [PW:0]   sre, sim;
  always_comb begin
    a_re = signed'(rda_q[2*DW-1:DW]);
    a_im = signed'(rda_q[DW-1:0]);
    b_re = signed'(rdb_q[2*DW-1:DW]);
    b_im = signed'(rdb_q[DW-1:0]);
    // round to nearest, ties up
    sre  = (PW+1)'(p_rr_q) - (PW+1)'(p_ii_q) + (PW+1)'(1 << (RND_SH - 1));
    sim  = (PW+1)'(p_ri_q) + (PW+1)'(p_ir_q) + (PW+1)'(1 << (RND_SH - 1));
  end

  // peak datapath (port a data)
  logic [DW-1:0] abs_re, abs_im;
  logic [SQW:0]  msum;
  logic [BW-1:0] rb;
  always_comb begin
    abs_re = a_re[DW-1] ? DW'(-a_re) : DW'(a_re);
    abs_im = a_im[DW-1] ? DW'(-a_im) : DW'(a_im);
    msum   = (SQW+1)'(sq_re_q) + (SQW+1)'(sq_im_q);
    rb     = r_q + bit_q;
  end

  // memory write ports
  logic               code_we, code_wd;
  logic [AW-1:0]      code_wa;
  logic               tmpl_we;
  logic [1:0]         tmpl_wd;
  logic               win_we;
  logic [AW-1:0]      win_wa;
  logic [2*SBITS-1:0] win_wd;
  logic               fft_we;
  logic [AW-1:0]      fft_wa, fft_ra;
  logic [2*DW-1:0]    fft_wd;
  always_comb begin
    code_we = (state_q == ST_CLR) || (accept && op_i == OP_LOAD);
    code_wa = (state_q == ST_CLR) ? cnt_q : index_i;
    code_wd = (state_q == ST_CLR) ? 1'b0 : prn_bit_i;
    tmpl_we = (state_q == ST_CLR) || (state_q == ST_BLD_WR);
    tmpl_wd = (state_q == ST_CLR) ? TC_POS : tc_n;
    win_we  = (state_q == ST_CLR) || (accept && op_i == OP_PUSH);
    win_wa  = (state_q == ST_CLR) ? cnt_q : hd_q;
    win_wd  = (state_q == ST_CLR) ? '0 : {sample_re_i, sample_im_i};
    fft_we  = (state_q == ST_LD_WR) || (state_q == ST_BF_WA) || (state_q == ST_BF_WB);
    fft_ra  = (state_q == ST_PK_RD) ? cnt_q : a_addr;
    case (state_q)
      ST_LD_WR: begin
        fft_wa = brev;
        fft_wd = {DW'(pr), DW'(pi)};
      end
      ST_BF_WA: begin
        fft_wa = a_addr;
        fft_wd = {DW'(a_re + tr_q), DW'(a_im + ti_q)};
      end
      default: begin
        fft_wa = b_addr;
        fft_wd = {DW'(a_re - tr_q), DW'(a_im - ti_q)};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (code_we) code_mem[code_wa] <= code_wd;
    code_rd_q <= code_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (tmpl_we) tmpl_mem[cnt_q] <= tmpl_wd;
    tmpl_rd_q <= tmpl_mem[cnt_q];
  end

  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[win_wa] <= win_wd;
    win_rd_q <= win_mem[AW'(hd_q + cnt_q)];
  end

  always_ff @(posedge clk_i) begin
    if (fft_we) fft_mem[fft_wa] <= fft_wd;
    if (state_q == ST_BF_RD || state_q == ST_PK_RD) begin
      rda_q <= fft_mem[fft_ra];
      rdb_q <= fft_mem[b_addr];
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_BF_RD: begin
        tw_re_q <= TW_RE[{1'b0, tw_idx}];
        tw_im_q <= TW_IM[{1'b0, tw_idx}];
      end
      ST_BF_MUL: begin
        p_rr_q <= b_re * tw_re_q;
        p_ii_q <= b_im * tw_im_q;
        p_ri_q <= b_re * tw_im_q;
        p_ir_q <= b_im * tw_re_q;
      end
      ST_BF_SUM: begin
        tr_q <= DW'(sre >>> RND_SH);
        ti_q <= DW'(sim >>> RND_SH);
      end
      ST_PK_SQ: begin
        sq_re_q <= abs_re[MAGW-1:0] * abs_re[MAGW-1:0];
        sq_im_q <= abs_im[MAGW-1:0] * abs_im[MAGW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cnt_q       <= '0;
      hd_q        <= '0;
      stg_q       <= '0;
      bfn_q       <= '0;
      prev_bit_q  <= 1'b0;
      iv_q        <= 1'b0;
      qv_q        <= 1'b0;
      best_q      <= '0;
      sat_q       <= 1'b0;
      v_q         <= '0;
      r_q         <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      peak_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_FIN) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_last) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          cnt_q <= '0;
          if (accept) begin
            case (op_i)
              OP_BUILD: state_q <= ST_BLD_RD;
              OP_PUSH: begin
                hd_q    <= hd_q + 1'b1;
                state_q <= ST_LD_RD;
              end
              default: ;
            endcase
          end
        end
        ST_BLD_RD: state_q <= ST_BLD_WR;
        ST_BLD_WR: begin
          prev_bit_q <= code_rd_q;
          iv_q       <= iv_n;
          qv_q       <= qv_n;
          cnt_q      <= cnt_q + 1'b1;
          state_q    <= cnt_last ? ST_IDLE : ST_BLD_RD;
        end
        ST_LD_RD: state_q <= ST_LD_WR;
        ST_LD_WR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_last) begin
            stg_q   <= '0;
            bfn_q   <= '0;
            state_q <= ST_BF_RD;
          end else begin
            state_q <= ST_LD_RD;
          end
        end
        ST_BF_RD:  state_q <= ST_BF_MUL;
        ST_BF_MUL: state_q <= ST_BF_SUM;
        ST_BF_SUM: state_q <= ST_BF_WA;
        ST_BF_WA:  state_q <= ST_BF_WB;
        ST_BF_WB: begin
          bfn_q <= bfn_q + 1'b1;
          if (&bfn_q) begin
            if (stg_q == STGW'(AW - 1)) begin
              cnt_q   <= '0;
              best_q  <= '0;
              sat_q   <= 1'b0;
              state_q <= ST_PK_RD;
            end else begin
              stg_q   <= stg_q + 1'b1;
              state_q <= ST_BF_RD;
            end
          end else begin
            state_q <= ST_BF_RD;
          end
        end
        ST_PK_RD: state_q <= ST_PK_SQ;
        ST_PK_SQ: begin
          if ((|abs_re[DW-1:MAGW]) || (|abs_im[DW-1:MAGW])) sat_q <= 1'b1;
          state_q <= ST_PK_CMP;
        end
        ST_PK_CMP: begin
          if (msum > best_q) best_q <= msum;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_last) begin
            v_q     <= BW'(msum > best_q ? msum : best_q);
            r_q     <= '0;
            bit_q   <= BW'(1) << (BW - 2);
            state_q <= ST_SQRT;
          end else begin
            state_q <= ST_PK_RD;
          end
        end
        ST_SQRT: begin
          if (v_q >= rb) begin
            v_q <= v_q - rb;
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q[0]) state_q <= ST_FIN;
        end
        ST_FIN: begin
          // hold the result until the output register frees up
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            peak_q      <= (sat_q || r_q > BW'(OUT_MAX)) ? OUT_MAX : r_q[MAGW-1:0];
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign peak_magnitude_o = peak_q;

  a_bf_addr_distinct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BF_RD |-> a_addr != b_addr && a_addr < b_addr)
    else $error("butterfly addresses collide");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op_i == OP_LOAD |=> state_q == ST_IDLE)
    else $error("code load left idle");

  a_sqrt_bit_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQRT |-> $onehot(bit_q))
    else $error("square root step bit lost");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("result raised outside final step");

endmodule

/* test/fft_peak_code_correlator_tb.sv */
module fft_peak_code_correlator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpcc_pkg::*;

  localparam int N = 512;
  localparam int LOG2N = 9;
  localparam longint unsigned PI30 = 64'd3373259426;
  localparam longint unsigned SAT = 64'd33554431;
  localparam longint CYCLE_LIMIT = 12_000_000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] op_i;
  logic [8:0] index_i;
  logic prn_bit_i;
  logic signed [15:0] sample_re_i;
  logic signed [15:0] sample_im_i;
  logic out_valid_o;
  logic out_stall_i;
  logic [24:0] peak_magnitude_o;

  fft_peak_code_correlator u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .op_i(op_i),
    .index_i(index_i),
    .prn_bit_i(prn_bit_i),
    .sample_re_i(sample_re_i),
    .sample_im_i(sample_im_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .peak_magnitude_o(peak_magnitude_o)
  );

  always #1 clk_i = ~clk_i;

  // predictor state
  bit code_mem[N];
  logic [1:0] symbol_mem[N];
  int win_re[N];
  int win_im[N];
  longint cos_tab[N/2+1];
  longint nsin_tab[N/2+1];

  logic [24:0] expected_peaks[$];
  int errors = 0;
  int items_sent = 0;
  int peaks_checked = 0;
  longint cycles = 0;
  bit quiet = 1'b0;

  function automatic longint unsigned rdiv(longint unsigned v, longint unsigned d);
    return (v + d / 2) / d;
  endfunction

  // sin and cos of a Q2.30 angle in [0, pi/4], Q1.17 results
  function automatic void taylor_q17(longint unsigned x, output longint s,
                                     output longint c);
    longint unsigned x2, ts, tc;
    longint ss, cs;
    x2 = (x * x + (64'd1 << 29)) >> 30;
    ts = x;
    tc = 64'd1 << 30;
    ss = longint'(x);
    cs = longint'(64'd1 << 30);
    for (int n = 1; n <= 7; n++) begin
      ts = rdiv((ts * x2 + (64'd1 << 29)) >> 30, 64'(2 * n * (2 * n + 1)));
      tc = rdiv((tc * x2 + (64'd1 << 29)) >> 30, 64'(2 * n * (2 * n - 1)));
      if (n % 2 == 1) begin
        ss -= longint'(ts);
        cs -= longint'(tc);
      end else begin
        ss += longint'(ts);
        cs += longint'(tc);
      end
    end
    if (ss < 0) ss = 0;
    if (cs < 0) cs = 0;
    s = (ss + 4096) >>> 13;
    c = (cs + 4096) >>> 13;
  endfunction

  function automatic void quarter_wave(int m, output longint s, output longint c);
    if (8 * m <= N) taylor_q17(rdiv(64'd2 * 64'(m) * PI30, N), s, c);
    else taylor_q17(rdiv(64'd2 * 64'(N / 4 - m) * PI30, N), c, s);
  endfunction

  function automatic void fill_twiddles();
    longint s, c;
    for (int k = 0; k <= N / 2; k++) begin
      if (4 * k <= N) begin
        quarter_wave(k, s, c);
      end else begin
        quarter_wave(N / 2 - k, s, c);
        c = -c;
      end
      cos_tab[k] = c;
      nsin_tab[k] = -s;
    end
  endfunction

  function automatic longint round_q17(longint v);
    v += 65536;
    if (v >= 0) return v >>> 17;
    return -(((-v) + 131071) >>> 17);
  endfunction

  function automatic void rebuild_symbols();
    bit d[N], iv[N], qv[N];
    d[0] = code_mem[0];
    for (int k = 1; k < N; k++) d[k] = code_mem[k] ^ code_mem[k-1];
    iv[0] = 1'b0;
    qv[0] = d[0];
    qv[1] = d[0];
    for (int k = 1; k + 2 < N; k += 2) begin
      iv[k] = d[k] ^ iv[k-1];
      iv[k+1] = iv[k];
    end
    iv[N-1] = d[N-1] ^ iv[N-2];
    for (int k = 2; k < N; k += 2) begin
      qv[k] = d[k] ^ iv[k-1];
      qv[k+1] = qv[k];
    end
    for (int k = 0; k < N; k++) begin
      case (k % 4)
        0: symbol_mem[k] = iv[k] ? TC_NEG : TC_POS;
        1: symbol_mem[k] = qv[k] ? TC_PJ : TC_NJ;
        2: symbol_mem[k] = iv[k] ? TC_POS : TC_NEG;
        default: symbol_mem[k] = qv[k] ? TC_NJ : TC_PJ;
      endcase
    end
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [24:0] correlate_peak();
    longint fre[N], fim[N];
    longint pr, pi, tr, ti;
    longint unsigned ar, ai, mag2, best;
    int r, a, b, w, half;
    for (int k = 0; k < N; k++) begin
      case (symbol_mem[k])
        TC_POS: begin pr = win_re[k]; pi = win_im[k]; end
        TC_PJ: begin pr = -win_im[k]; pi = win_re[k]; end
        TC_NEG: begin pr = -win_re[k]; pi = -win_im[k]; end
        default: begin pr = win_im[k]; pi = -win_re[k]; end
      endcase
      r = 0;
      for (int j = 0; j < LOG2N; j++) r = (r << 1) | ((k >> j) & 1);
      fre[r] = pr;
      fim[r] = pi;
    end
    for (int len = 2; len <= N; len *= 2) begin
      half = len / 2;
      for (int s = 0; s < N; s += len) begin
        for (int j = 0; j < half; j++) begin
          a = s + j;
          b = a + half;
          w = j * (N / len);
          tr = round_q17(fre[b] * cos_tab[w] - fim[b] * nsin_tab[w]);
          ti = round_q17(fre[b] * nsin_tab[w] + fim[b] * cos_tab[w]);
          fre[b] = fre[a] - tr;
          fim[b] = fim[a] - ti;
          fre[a] += tr;
          fim[a] += ti;
        end
      end
    end
    best = 0;
    for (int k = 0; k < N; k++) begin
      ar = fre[k] < 0 ? -fre[k] : fre[k];
      ai = fim[k] < 0 ? -fim[k] : fim[k];
      if (ar >= (64'd1 << 25) || ai >= (64'd1 << 25)) return SAT[24:0];
      mag2 = ar * ar + ai * ai;
      if (mag2 > best) best = mag2;
    end
    best = int_sqrt(best);
    return best > SAT ? SAT[24:0] : best[24:0];
  endfunction

  // apply one accepted item to the predictor
  function automatic void model_item(logic [1:0] op, logic [8:0] idx, bit b,
                                     logic signed [15:0] re, logic signed [15:0] im);
    case (op)
      OP_LOAD: code_mem[idx] = b;
      OP_BUILD: rebuild_symbols();
      OP_PUSH: begin
        for (int k = 0; k < N - 1; k++) begin
          win_re[k] = win_re[k+1];
          win_im[k] = win_im[k+1];
        end
        win_re[N-1] = re;
        win_im[N-1] = im;
        expected_peaks.push_back(correlate_peak());
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_item(logic [1:0] op, logic [8:0] idx, bit b,
                           logic signed [15:0] re, logic signed [15:0] im);
    int gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    index_i <= idx;
    prn_bit_i <= b;
    sample_re_i <= re;
    sample_im_i <= im;
    do @(posedge clk_i); while (in_stall_o);
    model_item(op, idx, b, re, im);
    items_sent++;
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 3)) - 16'sd2;
      default: return 16'($urandom);
    endcase
  endfunction

  // drop valid so the last item is not taken twice, then wait for every result
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_peaks.size() != 0) @(posedge clk_i);
  endtask

  // window starts empty and the template starts all +1
  task automatic test_reset_pushes();
    send_item(OP_PUSH, '0, 1'b0, 16'sh7fff, 16'sh8000);
    send_item(OP_PUSH, '0, 1'b0, 16'sh8000, 16'sh7fff);
    send_item(OP_PUSH, '0, 1'b0, 16'sh0000, 16'sh0000);
    send_item(OP_PUSH, '1, 1'b1, -16'sd1, -16'sd1);
  endtask

  task automatic test_ignored_ops();
    send_item(OP_NONE, '1, 1'b1, 16'sh7fff, 16'sh7fff);
    send_item(OP_NONE, '0, 1'b0, 16'sh8000, 16'sh8000);
    send_item(OP_BUILD, '1, 1'b1, 16'sh1234, 16'sh4321);
    send_item(OP_PUSH, '0, 1'b0, 16'sd100, -16'sd100);
  endtask

  task automatic test_code_build();
    send_item(OP_LOAD, 9'd0, 1'b1, '0, '0);
    send_item(OP_LOAD, 9'd511, 1'b1, '0, '0);
    send_item(OP_LOAD, 9'd255, 1'b1, '0, '0);
    send_item(OP_LOAD, 9'd256, 1'b1, '0, '0);
    send_item(OP_LOAD, 9'd170, 1'b1, '0, '0);
    send_item(OP_LOAD, 9'd511, 1'b0, '0, '0);
    send_item(OP_BUILD, '0, 1'b0, '0, '0);
    send_item(OP_PUSH, '0, 1'b0, 16'sh8000, 16'sh8000);
    send_item(OP_PUSH, '0, 1'b0, 16'sh7fff, 16'sh7fff);
    send_item(OP_PUSH, '0, 1'b0, 16'sh7fff, 16'sh8000);
  endtask

  // hold the sender until every peak is back, then build with no result due
  task automatic test_drain_pause();
    wait_drained();
    send_item(OP_BUILD, '0, 1'b0, '0, '0);
    send_item(OP_PUSH, '0, 1'b0, rand_sample(), rand_sample());
  endtask

  task automatic test_random_traffic(int target);
    int nloads, npush;
    while (items_sent < target) begin
      quiet = ($urandom_range(9) == 0);
      nloads = $urandom_range(0, 12);
      repeat (nloads)
        send_item(OP_LOAD, 9'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
      if ($urandom_range(9) != 0) send_item(OP_BUILD, 9'($urandom), 1'($urandom), '0, '0);
      npush = $urandom_range(1, 3);
      repeat (npush) send_item(OP_PUSH, 9'($urandom), 1'($urandom), rand_sample(),
                               rand_sample());
      if ($urandom_range(5) == 0)
        send_item(OP_NONE, 9'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
    end
    quiet = 1'b0;
  endtask

  // receiver back-pressure: runs of stall and of no stall
  int stall_run = 0;
  always @(negedge clk_i) begin
    if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      case ($urandom_range(9))
        0, 1, 2: begin out_stall_i <= 1'b1; stall_run <= $urandom_range(0, 3); end
        3: begin out_stall_i <= 1'b1; stall_run <= $urandom_range(20, 80); end
        default: begin out_stall_i <= 1'b0; stall_run <= $urandom_range(0, 10); end
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_peaks.size() == 0) begin
        $display("%0t: unexpected peak_magnitude %0d", $time, peak_magnitude_o);
        errors++;
      end else begin
        if (peak_magnitude_o !== expected_peaks[0]) begin
          $display("%0t: peak_magnitude expected %0d actual %0d", $time,
                   expected_peaks[0], peak_magnitude_o);
          errors++;
        end
        void'(expected_peaks.pop_front());
        peaks_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d peaks outstanding", $time, expected_peaks.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    op_i = OP_NONE;
    index_i = '0;
    prn_bit_i = 1'b0;
    sample_re_i = '0;
    sample_im_i = '0;
    for (int k = 0; k < N; k++) begin
      code_mem[k] = 1'b0;
      symbol_mem[k] = TC_POS;
      win_re[k] = 0;
      win_im[k] = 0;
    end
    fill_twiddles();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_pushes();
    test_ignored_ops();
    test_code_build();
    test_drain_pause();
    test_random_traffic(230);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (2000) @(posedge clk_i);

    $display("Covered %0d items (loads, builds, pushes, unused ops) and %0d peak results.",
             items_sent, peaks_checked);
    if (errors == 0 && expected_peaks.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
